// ===== hdl/ffca_pkg.sv =====
// Package for the first-fit chunk allocator.
// Holds the controller state type, the command codes and the fixed field widths.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

  // Command codes carried in the cmd field of a request beat.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Fixed field widths.
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned CHUNK_W = 17;
  localparam int unsigned FIDX_W  = 6;
  localparam int unsigned SIDX_W  = 6;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_CHUNK_BYTES = 1'b0;  // register select, paddr[2]
  localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RST = 17'd64;

  // Divider: numerator is bytes + chunk - 1, one quotient bit per cycle.
  localparam int unsigned DIV_NUM_W = 25;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd24;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } ffca_state_e;

endpackage : ffca_pkg

`default_nettype wire

// ===== hdl/ffca_if.sv =====
// Valid/ready channel interfaces of the chunk allocator: request and response.
// Depend on ffca_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffca_req_if;
  import ffca_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [BYTES_W-1:0]  req_bytes;
  logic [FIDX_W-1:0]   free_index;

  modport source (output valid, cmd, req_bytes, free_index, input ready);
  modport sink   (input valid, cmd, req_bytes, free_index, output ready);
endinterface : ffca_req_if

interface ffca_rsp_if;
  import ffca_pkg::*;
  logic                valid;
  logic                ready;
  logic                ok;
  logic [SIDX_W-1:0]   start_index;

  modport source (output valid, ok, start_index, input ready);
  modport sink   (input valid, ok, start_index, output ready);
endinterface : ffca_rsp_if

`default_nettype wire

// ===== hdl/first_fit_chunk_allocator_unit.sv =====
// Top level of the first-fit chunk allocator: controller, divider and cell row.
// Depends on ffca_pkg, ffca_if, ffca_div and ffca_cell.
//
//   Channel   Dir  Handshake             Beat contents
//   req_i     in   valid/ready           cmd, req_bytes, free_index
//   rsp_o     out  valid/ready           ok, start_index
//   APB       in   psel/penable/pwrite   chunk_bytes at byte address 0
//
// A free or an oversize allocate runs only the 25 divider steps for the chunk count before
// its result is decided; an allocate that scans then also sends the scan token along
// the row, one cell per cycle. The controller then loads the result and returns to idle
// to take the next beat.
// Reset clears all used flags at once and sets chunk_bytes to 64.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled response blocks only the hand-over of the next result.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_chunk_allocator_unit import ffca_pkg::*; #(
  parameter int unsigned NUM_CHUNKS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ffca_req_if.sink                   req_i,
  ffca_rsp_if.source                 rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHUNKS + 1);
  localparam int unsigned RNG_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [DIV_NUM_W-1:0]   POOL_Q   = DIV_NUM_W'(NUM_CHUNKS);
  localparam logic [DIV_NUM_W:0]     POOL_SUM = (DIV_NUM_W + 1)'(NUM_CHUNKS);
  localparam logic [RNG_W-1:0]       POOL_RNG = RNG_W'(NUM_CHUNKS);

  // ---------------------------------------------------------------------------
  // Configuration register.
  logic [CHUNK_W-1:0] chunk_bytes_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHUNK_BYTES);
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(chunk_bytes_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bytes_q <= CHUNK_BYTES_RST;
    end else if (cfg_wr) begin
      chunk_bytes_q <= pwdata[CHUNK_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Divider for the chunk count; a zero chunk size counts as one byte.
  logic [CHUNK_W-1:0]   chunk_eff;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quot;

  assign chunk_eff = (chunk_bytes_q == '0) ? CHUNK_W'(1) : chunk_bytes_q;
  assign div_num   = DIV_NUM_W'(req_i.req_bytes) + DIV_NUM_W'(chunk_eff) - DIV_NUM_W'(1);

  ffca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (chunk_eff),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // ---------------------------------------------------------------------------
  // Controller state and output register.
  ffca_state_e state_q, state_d;

  logic              out_vld_q;
  logic              out_ok_q;
  logic [SIDX_W-1:0] out_idx_q;

  logic              cmd_q;
  logic [FIDX_W-1:0] fidx_q;
  logic [CNT_W-1:0]  need_q;
  logic              pend_ok_q;
  logic [SIDX_W-1:0] pend_idx_q;
  logic              mark_pend_q;
  logic              mark_val_q;
  logic [RNG_W-1:0]  mark_lo_q;
  logic [RNG_W-1:0]  mark_hi_q;

  logic              req_rdy;
  logic              launch;
  logic              load_out;
  logic              too_big;
  logic [CNT_W-1:0]  need_alloc;
  logic [DIV_NUM_W:0] free_end;
  logic [RNG_W-1:0]  free_hi;

  // Token chain between cells; entry 0 is the launch point.
  logic             tok_vld   [NUM_CHUNKS+1];
  logic             tok_fnd   [NUM_CHUNKS+1];
  logic [CNT_W-1:0] tok_run   [NUM_CHUNKS+1];
  logic [IDX_W-1:0] tok_start [NUM_CHUNKS+1];

  logic             tail_vld;
  logic             tail_fnd;
  logic [IDX_W-1:0] tail_start;

  assign tail_vld   = tok_vld[NUM_CHUNKS];
  assign tail_fnd   = tok_fnd[NUM_CHUNKS];
  assign tail_start = tok_start[NUM_CHUNKS];

  // Request sizing from the quotient.
  assign too_big    = quot > POOL_Q;
  assign need_alloc = (quot == '0) ? CNT_W'(1) : CNT_W'(quot);
  assign free_end   = (DIV_NUM_W + 1)'(fidx_q) + (DIV_NUM_W + 1)'(quot);
  assign free_hi    = (free_end > POOL_SUM) ? POOL_RNG : RNG_W'(free_end);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (cmd_q == CMD_FREE || too_big) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tail_vld) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req_rdy  = 1'b0;
    launch   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: req_rdy  = 1'b1;
      ST_DIV:  launch   = div_done && (cmd_q == CMD_ALLOC) && !too_big;
      ST_SCAN: ;
      ST_DONE: load_out = !out_vld_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign div_start   = req_rdy && req_i.valid;
  assign req_i.ready = req_rdy;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item, pending result and range-update registers.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      cmd_q  <= req_i.cmd;
      fidx_q <= req_i.free_index;
    end
    if (state_q == ST_DIV && div_done) begin
      if (cmd_q == CMD_FREE) begin
        pend_ok_q   <= 1'b1;
        pend_idx_q  <= SIDX_W'(fidx_q);
        mark_pend_q <= 1'b1;
        mark_val_q  <= 1'b0;
        mark_lo_q   <= RNG_W'(fidx_q);
        mark_hi_q   <= free_hi;
      end else begin
        pend_ok_q   <= 1'b0;
        pend_idx_q  <= '0;
        mark_pend_q <= 1'b0;
        need_q      <= need_alloc;
      end
    end
    if (state_q == ST_SCAN && tail_vld) begin
      pend_ok_q   <= tail_fnd;
      pend_idx_q  <= tail_fnd ? SIDX_W'(tail_start) : '0;
      mark_pend_q <= tail_fnd;
      mark_val_q  <= 1'b1;
      mark_lo_q   <= RNG_W'(tail_start);
      mark_hi_q   <= RNG_W'(tail_start) + RNG_W'(need_q);
    end
    if (load_out) begin
      out_ok_q  <= pend_ok_q;
      out_idx_q <= pend_idx_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.start_index = out_idx_q;

  // ---------------------------------------------------------------------------
  // Row of chunk cells; the flags change together with the result hand-over.
  logic             mark_en;
  logic [CNT_W-1:0] need_row;
  assign mark_en = load_out && mark_pend_q;

  // The first cell sees the token in the cycle the run length is still being
  // registered, so it takes the length straight from the quotient.
  assign need_row = launch ? need_alloc : need_q;

  assign tok_vld[0]   = launch;
  assign tok_fnd[0]   = 1'b0;
  assign tok_run[0]   = '0;
  assign tok_start[0] = '0;

  for (genvar gi = 0; gi < NUM_CHUNKS; gi++) begin : g_cell
    ffca_cell #(
      .INDEX (gi),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .RNG_W (RNG_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_vld_i   (tok_vld[gi]),
      .tok_fnd_i   (tok_fnd[gi]),
      .tok_run_i   (tok_run[gi]),
      .tok_start_i (tok_start[gi]),
      .need_i      (need_row),
      .mark_en_i   (mark_en),
      .mark_val_i  (mark_val_q),
      .mark_lo_i   (mark_lo_q),
      .mark_hi_i   (mark_hi_q),
      .tok_vld_o   (tok_vld[gi+1]),
      .tok_fnd_o   (tok_fnd[gi+1]),
      .tok_run_o   (tok_run[gi+1]),
      .tok_start_o (tok_start[gi+1])
    );
  end

endmodule : first_fit_chunk_allocator_unit

`default_nettype wire

// ===== hdl/ffca_div.sv =====
// Restoring divider that turns a byte count into a chunk count, one bit per cycle.
// Depends on ffca_pkg for the operand widths and the iteration count.
`timescale 1ns / 1ps
`default_nettype none

module ffca_div import ffca_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [CHUNK_W-1:0]   den_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [CHUNK_W-1:0]   rem_q;
  logic [CHUNK_W-1:0]   den_q;

  logic [CHUNK_W:0]     shift_rem;
  logic                 fits;
  logic [CHUNK_W-1:0]   rem_d;

  // One restoring step: bring in the next numerator bit and try the subtract.
  always_comb begin
    shift_rem = {rem_q, num_q[DIV_NUM_W-1]};
    fits      = shift_rem >= {1'b0, den_q};
    if (fits) begin
      rem_d = CHUNK_W'(shift_rem - {1'b0, den_q});
    end else begin
      rem_d = CHUNK_W'(shift_rem);
    end
  end

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: the numerator register fills with quotient bits from the right.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule : ffca_div

`default_nettype wire

// ===== hdl/ffca_cell.sv =====
// One chunk cell: holds the used flag of its chunk and one stage of the scan token.
// Depends on ffca_pkg only for the house style; widths come from the parameters.
`timescale 1ns / 1ps
`default_nettype none

module ffca_cell import ffca_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned RNG_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Scan token from the left neighbor.
  input  wire logic             tok_vld_i,
  input  wire logic             tok_fnd_i,
  input  wire logic [CNT_W-1:0] tok_run_i,
  input  wire logic [IDX_W-1:0] tok_start_i,
  // Run length the scan is looking for.
  input  wire logic [CNT_W-1:0] need_i,
  // Range update broadcast: set or clear the flags in [lo, hi).
  input  wire logic             mark_en_i,
  input  wire logic             mark_val_i,
  input  wire logic [RNG_W-1:0] mark_lo_i,
  input  wire logic [RNG_W-1:0] mark_hi_i,
  // Scan token to the right neighbor.
  output logic                  tok_vld_o,
  output logic                  tok_fnd_o,
  output logic [CNT_W-1:0]      tok_run_o,
  output logic [IDX_W-1:0]      tok_start_o
);

  localparam logic [RNG_W-1:0] MY_IDX    = RNG_W'(INDEX);
  localparam logic [IDX_W-1:0] NEXT_IDX  = IDX_W'(INDEX + 1);

  logic             used_q;
  logic             vld_q;
  logic             fnd_q, fnd_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic             in_range;

  // Extend or restart the free run and check it against the request.
  always_comb begin
    if (tok_fnd_i) begin
      fnd_d   = 1'b1;
      run_d   = tok_run_i;
      start_d = tok_start_i;
    end else begin
      if (!used_q) begin
        run_d   = tok_run_i + CNT_W'(1);
        start_d = tok_start_i;
      end else begin
        run_d   = '0;
        start_d = NEXT_IDX;
      end
      fnd_d = run_d >= need_i;
    end
  end

  assign in_range = (MY_IDX >= mark_lo_i) && (MY_IDX < mark_hi_i);

  // Used flag and token valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      vld_q <= tok_vld_i;
      if (mark_en_i && in_range) begin
        used_q <= mark_val_i;
      end
    end
  end

  // Token payload stage.
  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      fnd_q   <= fnd_d;
      run_q   <= run_d;
      start_q <= start_d;
    end
  end

  assign tok_vld_o   = vld_q;
  assign tok_fnd_o   = fnd_q;
  assign tok_run_o   = run_q;
  assign tok_start_o = start_q;

endmodule : ffca_cell

`default_nettype wire

// ===== tb/sv/ffca_grant_checker.sv =====
// Checker for the first-fit chunk allocator: tracks the chunk size and the used map,
// predicts one grant per request beat and compares it with each response beat.
// Depends on ffca_pkg and the request/response interfaces in ffca_if.
`timescale 1ns / 1ps

module ffca_grant_checker import ffca_pkg::*; #(
  parameter int unsigned NUM_CHUNKS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ffca_req_if                        req,
  ffca_rsp_if                        rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  input  wire logic [APB_DATA_W-1:0] prdata,
  output int unsigned                error_count,
  output int unsigned                grants_pending,
  output int unsigned                grants_checked
);

  typedef struct packed {
    logic              ok;
    logic [SIDX_W-1:0] start_index;
  } grant_t;

  // Shadow of the chunk size register and of the used flags.
  logic [CHUNK_W-1:0]    chunk_shadow;
  logic [NUM_CHUNKS-1:0] used_map;
  grant_t                grants_due[$];

  assign grants_pending = grants_due.size();

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Number of chunks that a byte count covers; a zero chunk size counts as one byte.
  function automatic int unsigned chunk_count(input logic [BYTES_W-1:0] nbytes);
    int unsigned cb;
    cb = (chunk_shadow == '0) ? 1 : int'(chunk_shadow);
    return (int'(nbytes) + cb - 1) / cb;
  endfunction

  // Apply one request to the used map and queue the grant it produces.
  task automatic predict_grant(input logic cmd, input logic [BYTES_W-1:0] nbytes,
                               input logic [FIDX_W-1:0] fidx);
    int unsigned need;
    int unsigned run;
    int unsigned start;
    int unsigned i;
    int unsigned j;
    bit          found;
    grant_t      g;
    need  = chunk_count(nbytes);
    g     = '0;
    found = 1'b0;
    if (cmd == CMD_FREE) begin
      // Clearing stops at the end of the pool.
      for (i = 0; i < need && int'(fidx) + i < NUM_CHUNKS; i++) used_map[int'(fidx) + i] = 1'b0;
      g.ok          = 1'b1;
      g.start_index = fidx;
    end else begin
      if (need == 0) need = 1;
      if (need <= NUM_CHUNKS) begin
        run   = 0;
        start = 0;
        for (i = 0; i < NUM_CHUNKS && !found; i++) begin
          if (!used_map[i]) begin
            run++;
          end else begin
            run   = 0;
            start = i + 1;
          end
          if (run >= need) begin
            for (j = start; j < start + need; j++) used_map[j] = 1'b1;
            g.ok          = 1'b1;
            g.start_index = start[SIDX_W-1:0];
            found         = 1'b1;
          end
        end
      end
    end
    grants_due.push_back(g);
  endtask

  // All sampling happens at the rising edge, on values from before the edge.
  always @(posedge clk_i) begin
    grant_t want;
    if (!rst_ni) begin
      chunk_shadow <= CHUNK_BYTES_RST;
      used_map     <= '0;
      grants_due.delete();
      error_count    = 0;
      grants_checked = 0;
    end else begin
      // Response beat against the oldest grant still due.
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          report_error($sformatf("response beat ok=%0b start=%0d with no grant due",
                                 rsp.ok, rsp.start_index));
        end else begin
          want = grants_due.pop_front();
          grants_checked++;
          if (rsp.ok !== want.ok)
            report_error($sformatf("ok is %0b, expected %0b", rsp.ok, want.ok));
          if (rsp.start_index !== want.start_index)
            report_error($sformatf("start_index is %0d, expected %0d",
                                   rsp.start_index, want.start_index));
        end
      end
      // Request beat updates the map.
      if (req.valid && req.ready) predict_grant(req.cmd, req.req_bytes, req.free_index);
      // Register port: track writes, check reads.
      if (psel && penable && pready && paddr[2] == REG_CHUNK_BYTES) begin
        if (pwrite) begin
          chunk_shadow <= pwdata[CHUNK_W-1:0];
        end else if (prdata !== APB_DATA_W'(chunk_shadow)) begin
          report_error($sformatf("chunk_bytes reads %0d, expected %0d", prdata, chunk_shadow));
        end
      end
    end
  end

endmodule : ffca_grant_checker

// ===== tb/sv/testbench.sv =====
// Top of the allocator testbench: clock, reset, register writes, request stimulus,
// response back-pressure, watchdog and verdict. Depends on ffca_pkg, ffca_if,
// ffca_grant_checker and the first_fit_chunk_allocator_unit design.
`timescale 1ns / 1ps

module testbench;
  import ffca_pkg::*;

  localparam int unsigned POOL_CHUNKS   = 64;
  localparam int unsigned ITEMS_PER_SET = 107;
  localparam int unsigned NUM_SETS      = 7;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam logic [APB_ADDR_W-1:0] CHUNK_BYTES_ADDR = {REG_CHUNK_BYTES, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned error_count;
  int unsigned grants_pending;
  int unsigned grants_checked;
  int unsigned beats_sent;
  int unsigned idle_cycles;
  bit          calm;

  ffca_req_if req ();
  ffca_rsp_if rsp ();

  always #6 clk_i = ~clk_i;

  first_fit_chunk_allocator_unit #(.NUM_CHUNKS(POOL_CHUNKS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  ffca_grant_checker #(.NUM_CHUNKS(POOL_CHUNKS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req),
    .rsp           (rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .error_count   (error_count),
    .grants_pending(grants_pending),
    .grants_checked(grants_checked)
  );

  // Mostly no pause, often a short one, now and then a long one; none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Byte counts around whole multiples of the chunk size, plus zero and wild values.
  function automatic logic [BYTES_W-1:0] pick_bytes(input int unsigned cb,
                                                    input int unsigned max_k);
    int unsigned     cbe;
    int unsigned     k;
    int unsigned     r;
    longint unsigned b;
    cbe = (cb == 0) ? 1 : cb;
    r   = $urandom_range(0, 99);
    if (r < 5) return BYTES_W'($urandom);
    if (r < 10) return '0;
    k = (r < 82) ? $urandom_range(1, max_k) : $urandom_range(1, POOL_CHUNKS + 1);
    b = longint'(k) * cbe - $urandom_range(0, cbe - 1);
    if (b > 64'hFF_FFFF) b = 64'hFF_FFFF;
    return b[BYTES_W-1:0];
  endfunction

  // Full-pool byte count for the current chunk size, clipped to the field.
  function automatic logic [BYTES_W-1:0] pool_bytes(input int unsigned cb);
    longint unsigned b;
    b = longint'(POOL_CHUNKS) * ((cb == 0) ? 1 : cb);
    if (b > 64'hFF_FFFF) b = 64'hFF_FFFF;
    return b[BYTES_W-1:0];
  endfunction

  // One register access: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CHUNK_BYTES_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one request beat and hold it until accepted, then maybe pause.
  task automatic send_request(input logic cmd, input logic [BYTES_W-1:0] nbytes,
                              input logic [FIDX_W-1:0] fidx);
    int unsigned gap;
    req.valid      <= 1'b1;
    req.cmd        <= cmd;
    req.req_bytes  <= nbytes;
    req.free_index <= fidx;
    do @(posedge clk_i); while (!req.ready);
    beats_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid      <= 1'b0;
      req.cmd        <= 1'($urandom);
      req.req_bytes  <= BYTES_W'($urandom);
      req.free_index <= FIDX_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every grant has come back.
  task automatic drain_grants();
    req.valid <= 1'b0;
    while (grants_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Response back-pressure.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles.", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    int unsigned chunk_plan[NUM_SETS];
    int unsigned cb;
    int unsigned s;
    int unsigned n;
    int unsigned r;
    chunk_plan = '{1, 65536, 0, 7, 100, 0, 64};
    chunk_plan[5] = $urandom_range(2, 65535);
    calm           = 1'b1;
    beats_sent     = 0;
    idle_cycles    = 0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req.valid      <= 1'b0;
    req.cmd        <= CMD_ALLOC;
    req.req_bytes  <= '0;
    req.free_index <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0);

    // Directed walk at the reset chunk size of 64 bytes.
    send_request(CMD_ALLOC, 24'd0, '0);        // zero bytes still takes one chunk
    send_request(CMD_ALLOC, 24'd1, '0);
    send_request(CMD_ALLOC, 24'd64, '0);
    send_request(CMD_ALLOC, 24'd65, '0);       // rounds up to two chunks
    send_request(CMD_ALLOC, 24'd4097, '0);     // one byte over the pool
    send_request(CMD_ALLOC, 24'hFF_FFFF, '0);
    send_request(CMD_FREE, 24'd1, 6'd1);
    send_request(CMD_ALLOC, 24'd64, '0);       // reuses the hole at chunk 1
    send_request(CMD_ALLOC, 24'd3776, '0);     // fills the rest of the pool
    send_request(CMD_ALLOC, 24'd1, '0);        // pool full, no run fits
    send_request(CMD_FREE, 24'hFF_FFFF, 6'd63); // clipped at the pool end
    send_request(CMD_FREE, 24'd0, 6'd10);      // frees nothing
    send_request(CMD_FREE, 24'd320, 6'd20);
    send_request(CMD_FREE, 24'd320, 6'd20);    // already free
    send_request(CMD_ALLOC, 24'd384, '0);      // hole too short
    send_request(CMD_ALLOC, 24'd320, '0);
    send_request(CMD_FREE, 24'd4096, 6'd0);
    send_request(CMD_ALLOC, 24'd4096, '0);     // whole pool in one grant
    send_request(CMD_FREE, 24'd64, 6'd63);
    send_request(CMD_FREE, 24'd4096, 6'd0);
    drain_grants();

    // Random traffic under a series of chunk sizes.
    for (s = 0; s < NUM_SETS; s++) begin
      cb = chunk_plan[s];
      apb_access(1'b1, APB_DATA_W'(cb));
      apb_access(1'b0, '0);
      calm = (s % 3 == 2);
      for (n = 0; n < ITEMS_PER_SET; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_request(CMD_ALLOC, pick_bytes(cb, 6), FIDX_W'($urandom));
        else if (r < 60) send_request(CMD_FREE, pool_bytes(cb), '0);
        else send_request(CMD_FREE, pick_bytes(cb, 4), FIDX_W'($urandom));
      end
      drain_grants();
      calm = 1'b0;
    end

    repeat (100) @(posedge clk_i);
    $display("Summary: %0d request beats over %0d chunk sizes plus the reset size.",
             beats_sent, NUM_SETS);
    $display("Summary: %0d grants compared, %0d errors.", grants_checked, error_count);
    if (error_count == 0 && grants_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : testbench
